>>> rtl/swpd_pkg.sv
`timescale 1ns / 1ps

package swpd_pkg;

    // Field widths of the sample and peak items
    localparam int SAMPLE_W    = 16;
    localparam int PEAK_SIZE_W = 7;
    localparam int BEGIN_W     = 24;

    // Defaults for the top-level parameters
    localparam int MAX_WINDOW_DEF    = 64;
    localparam int POSITION_BITS_DEF = 24;

    // Window length after reset
    localparam logic [PEAK_SIZE_W-1:0] PEAK_SIZE_RESET = 7'd9;

endpackage

>>> rtl/swpd_sample_if.sv
`timescale 1ns / 1ps

interface swpd_sample_if;

    logic                                valid;
    logic                                ready;
    logic signed [swpd_pkg::SAMPLE_W-1:0] sample;
    logic                                sequence_start;

    modport source (
        output valid,
        output sample,
        output sequence_start,
        input  ready
    );

    modport sink (
        input  valid,
        input  sample,
        input  sequence_start,
        output ready
    );

endinterface

>>> rtl/swpd_peak_if.sv
`timescale 1ns / 1ps

interface swpd_peak_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [swpd_pkg::SAMPLE_W-1:0] peak_value;
    logic        [swpd_pkg::BEGIN_W-1:0]  window_begin;

    modport source (
        output valid,
        output peak_value,
        output window_begin,
        input  ready
    );

    modport sink (
        input  valid,
        input  peak_value,
        input  window_begin,
        output ready
    );

endinterface

>>> rtl/sliding_window_peak_detector_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake     Item payload
// -------   ---  ------------  -------------------------------------------
// samples   in   valid/ready   sample (s16 Q8.8), sequence_start (1b)
// peaks     out  valid/ready   peak_value (s16 Q8.8), window_begin (u24)
// cfg       in   cfg_wr_en     cfg_wr_data: peak_size (u7), no read-back
//
// One item per cycle sustained while peaks is not stalled. An accepted item
// lands in the input register; the strict-maximum test then runs in parallel
// over the live taps of the shifted window, and when the test stage advances
// the window taps and the result register that drives peaks.valid load. The
// input register and the result register are the only two stages, with the
// single compare pass between them.
// Reset (rst_n, async, low) clears fill count, position and both valid
// flags, and loads peak_size with 9. The window taps hold no reset value.
// A stall on peaks holds the result; the input register still takes one
// more item, after which samples.ready drops until the result is taken.

module sliding_window_peak_detector_core #(
    parameter int MAX_WINDOW    = swpd_pkg::MAX_WINDOW_DEF,
    parameter int POSITION_BITS = swpd_pkg::POSITION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [swpd_pkg::PEAK_SIZE_W-1:0]    cfg_wr_data,
    swpd_sample_if.sink                         samples,
    swpd_peak_if.source                         peaks
);

    localparam int IDX_W   = $clog2(MAX_WINDOW);
    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W   = (CNT_W > swpd_pkg::PEAK_SIZE_W) ? CNT_W : swpd_pkg::PEAK_SIZE_W;
    localparam int BCALC_W = (POSITION_BITS > swpd_pkg::BEGIN_W) ?
                             POSITION_BITS : swpd_pkg::BEGIN_W;
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [CNT_W-1:0]         WIN_MAX = CNT_W'(MAX_WINDOW);

    // Configuration register
    logic [swpd_pkg::PEAK_SIZE_W-1:0] peak_size_reg;

    // Input register
    logic                                 in_valid_reg;
    logic signed [swpd_pkg::SAMPLE_W-1:0] sample_reg;
    logic                                 start_reg;

    // Window state: entry 0 is the newest sample
    logic signed [swpd_pkg::SAMPLE_W-1:0] win_reg [MAX_WINDOW];
    logic signed [swpd_pkg::SAMPLE_W-1:0] win_next [MAX_WINDOW];
    logic [CNT_W-1:0]                     fill_reg;
    logic [CNT_W-1:0]                     fill_next;
    logic [POSITION_BITS-1:0]             pos_reg;
    logic [POSITION_BITS-1:0]             pos_next;

    // Result register
    logic                                 res_valid_reg;
    logic signed [swpd_pkg::SAMPLE_W-1:0] res_value_reg;
    logic [swpd_pkg::BEGIN_W-1:0]         res_begin_reg;

    // Test logic
    logic                                 adv;
    logic [CMP_W-1:0]                     ps_wide;
    logic [CNT_W-1:0]                     n_eff;
    logic [CNT_W-1:0]                     n_m1;
    logic [CNT_W-1:0]                     centre_wide;
    logic [IDX_W-1:0]                     centre;
    logic [CNT_W-1:0]                     fill_base;
    logic [POSITION_BITS-1:0]             idx;
    logic signed [swpd_pkg::SAMPLE_W-1:0] cval;
    logic                                 all_lower;
    logic                                 is_peak;
    logic [BCALC_W-1:0]                   begin_wide;

    // Advance the test stage when an item is held and the result slot is free or being drained
    assign adv           = in_valid_reg && (!res_valid_reg || peaks.ready);
    assign samples.ready = !in_valid_reg || adv;

    assign peaks.valid        = res_valid_reg;
    assign peaks.peak_value   = res_value_reg;
    assign peaks.window_begin = res_begin_reg;

    // Clamp the window length into 1..MAX_WINDOW
    always_comb
    begin
        ps_wide = CMP_W'(peak_size_reg);
        if (ps_wide == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (ps_wide > CMP_W'(WIN_MAX))
        begin
            n_eff = WIN_MAX;
        end
        else
        begin
            n_eff = CNT_W'(ps_wide);
        end
        n_m1        = n_eff - CNT_W'(1);
        // oldest tap is n-1; the centre sits n/2 taps newer
        centre_wide = n_m1 - (n_eff >> 1);
        centre      = centre_wide[IDX_W-1:0];
    end

    // Shift the new sample in, restart counters on a sequence start
    always_comb
    begin
        win_next[0] = sample_reg;
        for (int i = 1; i < MAX_WINDOW; i++)
        begin
            win_next[i] = win_reg[i-1];
        end

        fill_base = start_reg ? '0 : fill_reg;
        fill_next = (fill_base < WIN_MAX) ? fill_base + CNT_W'(1) : fill_base;

        idx      = start_reg ? '0 : pos_reg;
        pos_next = (idx != POS_MAX) ? idx + POSITION_BITS'(1) : idx;
    end

    // Strict-maximum test of the centre tap against every other live tap
    always_comb
    begin
        cval = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            if (IDX_W'(i) == centre)
            begin
                cval = win_next[i];
            end
        end

        all_lower = 1'b1;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            if ((CNT_W'(i) < n_eff) && (IDX_W'(i) != centre) && (win_next[i] >= cval))
            begin
                all_lower = 1'b0;
            end
        end

        is_peak = (fill_next >= n_eff) && all_lower;

        // window start, floored at zero
        if (BCALC_W'(idx) >= BCALC_W'(n_m1))
        begin
            begin_wide = BCALC_W'(idx) - BCALC_W'(n_m1);
        end
        else
        begin
            begin_wide = '0;
        end
    end

    // Configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_size_reg <= swpd_pkg::PEAK_SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            peak_size_reg <= cfg_wr_data;
        end
    end

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            in_valid_reg <= samples.valid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            sample_reg <= samples.sample;
            start_reg  <= samples.sequence_start;
        end
    end

    // Window taps: payload only, held until the next advance
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < MAX_WINDOW; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    // Fill count and position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            pos_reg  <= '0;
        end
        else if (adv)
        begin
            fill_reg <= fill_next;
            pos_reg  <= pos_next;
        end
    end

    // Result valid: load on advance, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= is_peak;
        end
        else if (peaks.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (adv && is_peak)
        begin
            res_value_reg <= cval;
            res_begin_reg <= begin_wide[swpd_pkg::BEGIN_W-1:0];
        end
    end

`ifndef SYNTHESIS
    // Fill count never runs past the window depth
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= WIN_MAX)
    else $error("fill count above window depth");

    // Every processed sample leaves at least one live tap
    assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> fill_reg != '0)
    else $error("fill count zero after a sample");

    // A sequence start places the next sample at position one
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && start_reg) |=> pos_reg == POSITION_BITS'(1))
    else $error("position not restarted on sequence start");

    // A result appears only from an advance of the test stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(adv))
    else $error("result raised without an advance");
`endif

endmodule
